// ===== design/cec_pkg.sv =====
// ----------------------------------------------------------------------------
// cec_pkg: shared types and constants for the calendar/epoch converter
// Request and result records, sequencer states and adder operation codes.
// ----------------------------------------------------------------------------
package cec_pkg;

  // One conversion request as captured from the input beat
  typedef struct packed {
    logic        func;
    logic [31:0] epoch_in;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
  } cec_req_t;

  // One conversion result, already masked per direction
  typedef struct packed {
    logic        ok;
    logic [31:0] epoch_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [2:0]  weekday;
  } cec_res_t;

  // Handshake between the sequencer and the output stage
  typedef struct packed {
    logic busy;
    logic done;
  } cec_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RANGE,
    S_YR4,
    S_YR1,
    S_MON,
    S_DAY10,
    S_DAY1,
    S_HR10,
    S_HR1,
    S_MIN10,
    S_MIN1,
    S_SEC,
    S_DONE
  } cec_state_t;

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } cec_op_t;

  localparam logic [31:0] EPOCH_LO    = 32'd1704067200;  // 2024-01-01 00:00:00
  localparam logic [31:0] EPOCH_SPAN  = 32'd2398377600;  // up to 2100-01-01
  localparam logic [11:0] YEAR_LO     = 12'd2024;
  localparam logic [11:0] YEAR_LAST   = 12'd2099;
  localparam logic [31:0] SECS_4YR    = 32'd126230400;   // 1461 days
  localparam logic [31:0] SECS_LEAPYR = 32'd31622400;    // 366 days
  localparam logic [31:0] SECS_YEAR   = 32'd31536000;    // 365 days
  localparam logic [31:0] SECS_10DAY  = 32'd864000;
  localparam logic [31:0] SECS_DAY    = 32'd86400;
  localparam logic [31:0] SECS_10HR   = 32'd36000;
  localparam logic [31:0] SECS_HR     = 32'd3600;
  localparam logic [31:0] SECS_10MIN  = 32'd600;
  localparam logic [31:0] SECS_MIN    = 32'd60;
  localparam logic [2:0]  WDAY_2024   = 3'd1;            // 2024-01-01 was a Monday

endpackage

// ===== design/cec_alu.sv =====
// ----------------------------------------------------------------------------
// cec_alu: shared 32-bit add/subtract unit
// Every step of the sequencer goes through this one adder; borrow flags a
// subtraction that would go below zero.
// ----------------------------------------------------------------------------
module cec_alu (
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  input  cec_pkg::cec_op_t op,
  output logic [31:0]      res,
  output logic             borrow
);
  import cec_pkg::*;

  logic [32:0] wide;

  always_comb begin
    if (op == OP_SUB) begin
      wide = {1'b0, a} - {1'b0, b};
    end else begin
      wide = {1'b0, a} + {1'b0, b};
    end
  end

  assign res    = wide[31:0];
  assign borrow = (op == OP_SUB) && wide[32];

endmodule

// ===== design/cec_seq.sv =====
// ----------------------------------------------------------------------------
// cec_seq: conversion sequencer
// Walks years, months, days, hours and minutes one step a cycle through the
// shared adder, adding toward an epoch or subtracting down to a calendar.
// ----------------------------------------------------------------------------
module cec_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  cec_pkg::cec_req_t req,
  input  logic              out_free,
  output cec_pkg::cec_ctl_t ctl,
  output cec_pkg::cec_res_t res
);
  import cec_pkg::*;

  cec_state_t  state, state_next;
  cec_req_t    req_r, req_r_next;
  logic [31:0] acc, acc_next;
  logic [11:0] year, year_next;
  logic [3:0]  month, month_next;
  logic [4:0]  day, day_next;
  logic [4:0]  hour, hour_next;
  logic [5:0]  minute, minute_next;
  logic [5:0]  second, second_next;
  logic [2:0]  wday, wday_next;
  logic        fail, fail_next;

  logic [31:0] alu_a, alu_b, alu_res;
  cec_op_t     alu_op;
  logic        alu_borrow;
  logic        take;
  logic        leap;
  logic        cal_ok;

  // Within 2024..2099 every year divisible by four is a leap year
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic lp);
    logic [4:0] d;
    unique case (m)
      4'd2:                   d = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      default:                d = 5'd0;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] month_secs(input logic [3:0] m, input logic lp);
    logic [31:0] s;
    unique case (days_in_month(m, lp))
      5'd28:   s = 32'd2419200;
      5'd29:   s = 32'd2505600;
      5'd30:   s = 32'd2592000;
      default: s = 32'd2678400;
    endcase
    return s;
  endfunction

  // Weekday advance of a whole month: month length mod 7
  function automatic logic [2:0] month_wstep(input logic [3:0] m, input logic lp);
    logic [2:0] w;
    unique case (days_in_month(m, lp))
      5'd28:   w = 3'd0;
      5'd29:   w = 3'd1;
      5'd30:   w = 3'd2;
      default: w = 3'd3;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] wday_add(input logic [2:0] w, input logic [2:0] d);
    logic [3:0] s;
    s = {1'b0, w} + {1'b0, d};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  cec_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .op     (alu_op),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  assign leap = (year[1:0] == 2'd0);

  assign cal_ok = (req_r.year_in >= YEAR_LO) && (req_r.year_in <= YEAR_LAST) &&
                  (req_r.month_in >= 4'd1) && (req_r.month_in <= 4'd12) &&
                  (req_r.day_in >= 5'd1) &&
                  (req_r.day_in <= days_in_month(req_r.month_in, req_r.year_in[1:0] == 2'd0)) &&
                  (req_r.hour_in <= 5'd23) && (req_r.minute_in <= 6'd59) &&
                  (req_r.second_in <= 6'd59);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_r_next;
    acc    <= acc_next;
    year   <= year_next;
    month  <= month_next;
    day    <= day_next;
    hour   <= hour_next;
    minute <= minute_next;
    second <= second_next;
    wday   <= wday_next;
    fail   <= fail_next;
  end

  always_comb begin
    state_next  = state;
    req_r_next  = req_r;
    acc_next    = acc;
    year_next   = year;
    month_next  = month;
    day_next    = day;
    hour_next   = hour;
    minute_next = minute;
    second_next = second;
    wday_next   = wday;
    fail_next   = fail;
    alu_a       = acc;
    alu_b       = '0;
    alu_op      = req_r.func ? OP_SUB : OP_ADD;
    take        = 1'b0;
    ctl.busy    = (state != S_IDLE);
    ctl.done    = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_r_next  = req;
          year_next   = YEAR_LO;
          month_next  = 4'd1;
          day_next    = 5'd1;
          hour_next   = '0;
          minute_next = '0;
          second_next = '0;
          wday_next   = WDAY_2024;
          fail_next   = 1'b0;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        // Rebase to 2024-01-01: subtract for epoch input, seed for calendar input
        alu_a    = req_r.func ? req_r.epoch_in : 32'd0;
        alu_b    = EPOCH_LO;
        acc_next = alu_res;
        if (req_r.func) begin
          if (alu_borrow) begin
            fail_next  = 1'b1;
            state_next = S_DONE;
          end else begin
            state_next = S_RANGE;
          end
        end else if (!cal_ok) begin
          fail_next  = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_YR4;
        end
      end
      S_RANGE: begin
        alu_b = EPOCH_SPAN;
        if (!alu_borrow) begin
          fail_next  = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_YR4;
        end
      end
      S_YR4: begin
        alu_b = SECS_4YR;
        take  = req_r.func ? !alu_borrow :
                (({1'b0, year} + 13'd4) <= {1'b0, req_r.year_in});
        if (take) begin
          acc_next  = alu_res;
          year_next = year + 12'd4;
          wday_next = wday_add(wday, 3'd5);
        end else begin
          state_next = S_YR1;
        end
      end
      S_YR1: begin
        alu_b = leap ? SECS_LEAPYR : SECS_YEAR;
        take  = req_r.func ? !alu_borrow : (year < req_r.year_in);
        if (take) begin
          acc_next  = alu_res;
          year_next = year + 12'd1;
          wday_next = wday_add(wday, leap ? 3'd2 : 3'd1);
        end else begin
          state_next = S_MON;
        end
      end
      S_MON: begin
        alu_b = month_secs(month, leap);
        take  = req_r.func ? (!alu_borrow && (month < 4'd12)) : (month < req_r.month_in);
        if (take) begin
          acc_next   = alu_res;
          month_next = month + 4'd1;
          wday_next  = wday_add(wday, month_wstep(month, leap));
        end else begin
          state_next = S_DAY10;
        end
      end
      S_DAY10: begin
        alu_b = SECS_10DAY;
        take  = req_r.func ? !alu_borrow :
                (({1'b0, day} + 6'd10) <= {1'b0, req_r.day_in});
        if (take) begin
          acc_next  = alu_res;
          day_next  = day + 5'd10;
          wday_next = wday_add(wday, 3'd3);
        end else begin
          state_next = S_DAY1;
        end
      end
      S_DAY1: begin
        alu_b = SECS_DAY;
        take  = req_r.func ? !alu_borrow : (day < req_r.day_in);
        if (take) begin
          acc_next  = alu_res;
          day_next  = day + 5'd1;
          wday_next = wday_add(wday, 3'd1);
        end else begin
          state_next = S_HR10;
        end
      end
      S_HR10: begin
        alu_b = SECS_10HR;
        take  = req_r.func ? !alu_borrow :
                (({1'b0, hour} + 6'd10) <= {1'b0, req_r.hour_in});
        if (take) begin
          acc_next  = alu_res;
          hour_next = hour + 5'd10;
        end else begin
          state_next = S_HR1;
        end
      end
      S_HR1: begin
        alu_b = SECS_HR;
        take  = req_r.func ? !alu_borrow : (hour < req_r.hour_in);
        if (take) begin
          acc_next  = alu_res;
          hour_next = hour + 5'd1;
        end else begin
          state_next = S_MIN10;
        end
      end
      S_MIN10: begin
        alu_b = SECS_10MIN;
        take  = req_r.func ? !alu_borrow :
                (({1'b0, minute} + 7'd10) <= {1'b0, req_r.minute_in});
        if (take) begin
          acc_next    = alu_res;
          minute_next = minute + 6'd10;
        end else begin
          state_next = S_MIN1;
        end
      end
      S_MIN1: begin
        alu_b = SECS_MIN;
        take  = req_r.func ? !alu_borrow : (minute < req_r.minute_in);
        if (take) begin
          acc_next    = alu_res;
          minute_next = minute + 6'd1;
        end else begin
          state_next = S_SEC;
        end
      end
      S_SEC: begin
        // Epoch input: what is left is below one minute
        if (req_r.func) begin
          second_next = acc[5:0];
        end else begin
          alu_b    = {26'd0, req_r.second_in};
          acc_next = alu_res;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl.done   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res            = '0;
    res.ok         = !fail;
    if (!fail && !req_r.func) begin
      res.epoch_out = acc;
    end
    if (!fail && req_r.func) begin
      res.year_out   = year;
      res.month_out  = month;
      res.day_out    = day;
      res.hour_out   = hour;
      res.minute_out = minute;
      res.second_out = second;
      res.weekday    = wday;
    end
  end

endmodule

// ===== design/calendar_epoch_converter.sv =====
// ----------------------------------------------------------------------------
// calendar_epoch_converter: Unix seconds <-> Gregorian UTC, years 2024..2099
// Two-way converter built around one shared 32-bit adder and a step
// sequencer; results leave through a registered output stage.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | beat contents
//   --------+----------------------+---------------------------------------------
//   in      | in_valid / in_stall  | func, epoch_in, year_in .. second_in
//   out     | out_valid / out_stall| ok, epoch_out, year_out .. second_out, weekday
//
// Steps: a rejected calendar beat or an epoch before 2024 goes from the check
//   straight to the done state, an epoch from 2100 on fails at the range check,
//   and any other beat walks the year-block, year, month, ten-day, day,
//   ten-hour, hour, ten-minute and minute steps, each phase ending on a step
//   that takes nothing, and then the seconds step. All steps share the single
//   32-bit add/subtract unit.
// Reset: rst returns the sequencer to idle and clears the output valid flag.
// Stalls: in_stall stays high while a conversion is in flight; a finished
//   result waits in the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module calendar_epoch_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] epoch_in,
  input  logic [11:0] year_in,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  input  logic [4:0]  hour_in,
  input  logic [5:0]  minute_in,
  input  logic [5:0]  second_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [31:0] epoch_out,
  output logic [11:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out,
  output logic [2:0]  weekday
);
  import cec_pkg::*;

  cec_req_t req;
  cec_res_t seq_res;
  cec_res_t res_q;
  cec_ctl_t ctl;
  logic     in_take;
  logic     out_free;

  // Accept a beat only while the sequencer sits idle
  assign in_stall = ctl.busy;
  assign in_take  = in_valid && !in_stall;

  // Output register is free when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    req.func      = func;
    req.epoch_in  = epoch_in;
    req.year_in   = year_in;
    req.month_in  = month_in;
    req.day_in    = day_in;
    req.hour_in   = hour_in;
    req.minute_in = minute_in;
    req.second_in = second_in;
  end

  cec_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_take),
    .req      (req),
    .out_free (out_free),
    .ctl      (ctl),
    .res      (seq_res)
  );

  // Hold the result until taken; load a new one when the sequencer hands it over
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      res_q <= seq_res;
    end
  end

  assign ok         = res_q.ok;
  assign epoch_out  = res_q.epoch_out;
  assign year_out   = res_q.year_out;
  assign month_out  = res_q.month_out;
  assign day_out    = res_q.day_out;
  assign hour_out   = res_q.hour_out;
  assign minute_out = res_q.minute_out;
  assign second_out = res_q.second_out;
  assign weekday    = res_q.weekday;

endmodule
